### hw/rtl/sqf_pkg.sv
`default_nettype none

package sqf_pkg;

    // Register map, in order of byte address.
    typedef enum logic [2:0] {
        REG_BP_B0,
        REG_BP_B1,
        REG_BP_B2,
        REG_LP_B0,
        REG_LP_B1,
        REG_LP_B2,
        REG_POLE_A1,
        REG_POLE_A2
    } reg_idx_t;

    localparam int NUM_REGS  = 8;
    localparam int IDX_WIDTH = 3;

    // Filter history carries this many fraction bits below the sample LSB.
    localparam int HIST_FRAC = 16;

    // Growth bits for a sum of three and of five products.
    localparam int FF_GUARD  = 2;
    localparam int ACC_GUARD = 3;

endpackage

`default_nettype wire

### hw/rtl/sqf_regs.sv
`default_nettype none

module sqf_regs
    import sqf_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 5
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ADDR_WIDTH-1:0]        paddr,
    input  wire logic [DATA_WIDTH-1:0]        pwdata,
    output logic      [DATA_WIDTH-1:0]        prdata,
    output logic                              pready,
    output logic signed [COEF_WIDTH-1:0]      bp_b0,
    output logic signed [COEF_WIDTH-1:0]      bp_b1,
    output logic signed [COEF_WIDTH-1:0]      bp_b2,
    output logic signed [COEF_WIDTH-1:0]      lp_b0,
    output logic signed [COEF_WIDTH-1:0]      lp_b1,
    output logic signed [COEF_WIDTH-1:0]      lp_b2,
    output logic signed [COEF_WIDTH-1:0]      pole_a1,
    output logic signed [COEF_WIDTH-1:0]      pole_a2
);

    localparam int ADDR_LSB = ADDR_WIDTH - IDX_WIDTH;

    logic signed [COEF_WIDTH-1:0] coef_reg [NUM_REGS];
    logic [IDX_WIDTH-1:0]         idx;
    logic                         wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_WIDTH-1:ADDR_LSB];
    assign wr_en  = psel && penable && pwrite && pready;

    // Coefficient registers, written in the access phase of a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            coef_reg[idx] <= $signed(pwdata[COEF_WIDTH-1:0]);
        end
    end

    // Read data is the sign-extended coefficient.
    assign prdata = DATA_WIDTH'(coef_reg[idx]);

    assign bp_b0   = coef_reg[REG_BP_B0];
    assign bp_b1   = coef_reg[REG_BP_B1];
    assign bp_b2   = coef_reg[REG_BP_B2];
    assign lp_b0   = coef_reg[REG_LP_B0];
    assign lp_b1   = coef_reg[REG_LP_B1];
    assign lp_b2   = coef_reg[REG_LP_B2];
    assign pole_a1 = coef_reg[REG_POLE_A1];
    assign pole_a2 = coef_reg[REG_POLE_A2];

endmodule

`default_nettype wire

### hw/rtl/sqf_feedforward.sv
`default_nettype none

module sqf_feedforward
    import sqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32
)
(
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic signed [COEF_WIDTH-1:0]                  bp_b0,
    input  wire logic signed [COEF_WIDTH-1:0]                  bp_b1,
    input  wire logic signed [COEF_WIDTH-1:0]                  bp_b2,
    input  wire logic signed [COEF_WIDTH-1:0]                  lp_b0,
    input  wire logic signed [COEF_WIDTH-1:0]                  lp_b1,
    input  wire logic signed [COEF_WIDTH-1:0]                  lp_b2,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]                in_sample,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                     out_sample,
    output logic signed [COEF_WIDTH+SAMPLE_WIDTH+FF_GUARD-1:0] ff_alpha,
    output logic signed [COEF_WIDTH+SAMPLE_WIDTH+FF_GUARD-1:0] ff_beta
);

    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int FF_WIDTH   = PROD_WIDTH + FF_GUARD;

    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev2_sample_reg;
    logic signed [FF_WIDTH-1:0]     ff_alpha_reg;
    logic signed [FF_WIDTH-1:0]     ff_beta_reg;
    logic signed [FF_WIDTH-1:0]     ff_alpha_next;
    logic signed [FF_WIDTH-1:0]     ff_beta_next;
    logic signed [PROD_WIDTH-1:0]   pa0, pa1, pa2, pb0, pb1, pb2;
    logic                           load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Numerator terms of both sections on the current and two past samples.
    always_comb
    begin
        pa0 = bp_b0 * in_sample;
        pa1 = bp_b1 * prev_sample_reg;
        pa2 = bp_b2 * prev2_sample_reg;
        pb0 = lp_b0 * in_sample;
        pb1 = lp_b1 * prev_sample_reg;
        pb2 = lp_b2 * prev2_sample_reg;
        ff_alpha_next = FF_WIDTH'(pa0) + FF_WIDTH'(pa1) + FF_WIDTH'(pa2);
        ff_beta_next  = FF_WIDTH'(pb0) + FF_WIDTH'(pb1) + FF_WIDTH'(pb2);
    end

    // Stage valid and the sample delay line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            prev_sample_reg  <= '0;
            prev2_sample_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                prev_sample_reg  <= in_sample;
                prev2_sample_reg <= prev_sample_reg;
            end
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg   <= in_sample;
            ff_alpha_reg <= ff_alpha_next;
            ff_beta_reg  <= ff_beta_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign ff_alpha   = ff_alpha_reg;
    assign ff_beta    = ff_beta_reg;

    // The delay line advances by exactly one sample per item.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (prev_sample_reg == $past(in_sample))
              && (prev2_sample_reg == $past(prev_sample_reg)))
        else $error("sample delay line did not advance with the item");

endmodule

`default_nettype wire

### hw/rtl/sqf_feedback.sv
`default_nettype none

module sqf_feedback
    import sqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32
)
(
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic signed [COEF_WIDTH-1:0]                  pole_a1,
    input  wire logic signed [COEF_WIDTH-1:0]                  pole_a2,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]                in_sample,
    input  wire logic signed [COEF_WIDTH+SAMPLE_WIDTH+FF_GUARD-1:0] ff_alpha,
    input  wire logic signed [COEF_WIDTH+SAMPLE_WIDTH+FF_GUARD-1:0] ff_beta,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                     out_sample,
    output logic signed [SAMPLE_WIDTH+HIST_FRAC-1:0]           y_alpha,
    output logic signed [SAMPLE_WIDTH+HIST_FRAC-1:0]           y_beta
);

    localparam int FF_WIDTH   = COEF_WIDTH + SAMPLE_WIDTH + FF_GUARD;
    localparam int HIST_WIDTH = SAMPLE_WIDTH + HIST_FRAC;
    localparam int PROD_WIDTH = COEF_WIDTH + HIST_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + ACC_GUARD;
    localparam int COEF_FRAC  = COEF_WIDTH - 2;
    localparam int SHIFTED_W  = ACC_WIDTH + 1 - COEF_FRAC;
    localparam logic [ACC_WIDTH:0] RND_HALF = (ACC_WIDTH + 1)'(1) << (COEF_FRAC - 1);

    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [HIST_WIDTH-1:0]   alpha_hist1_reg;
    logic signed [HIST_WIDTH-1:0]   alpha_hist2_reg;
    logic signed [HIST_WIDTH-1:0]   beta_hist1_reg;
    logic signed [HIST_WIDTH-1:0]   beta_hist2_reg;
    logic signed [HIST_WIDTH-1:0]   alpha_next;
    logic signed [HIST_WIDTH-1:0]   beta_next;
    logic                           load;

    // One section: feedforward sum minus the pole terms, rounded half-up
    // to the history grid and saturated to the history width.
    function automatic logic signed [HIST_WIDTH-1:0] section(
        input logic signed [FF_WIDTH-1:0]   ff,
        input logic signed [HIST_WIDTH-1:0] h1,
        input logic signed [HIST_WIDTH-1:0] h2,
        input logic signed [COEF_WIDTH-1:0] a1,
        input logic signed [COEF_WIDTH-1:0] a2
    );
        logic signed [PROD_WIDTH-1:0] fb1;
        logic signed [PROD_WIDTH-1:0] fb2;
        logic signed [ACC_WIDTH-1:0]  acc;
        logic [ACC_WIDTH:0]           rnd;
        logic [SHIFTED_W-1:0]         shifted;
        logic [SHIFTED_W-HIST_WIDTH:0] top;
        fb1     = a1 * h1;
        fb2     = a2 * h2;
        acc     = (ACC_WIDTH'(ff) <<< HIST_FRAC) - ACC_WIDTH'(fb1) - ACC_WIDTH'(fb2);
        rnd     = (ACC_WIDTH + 1)'(acc) + RND_HALF;
        shifted = rnd[ACC_WIDTH:COEF_FRAC];
        top     = shifted[SHIFTED_W-1:HIST_WIDTH-1];
        if ((&top) || !(|top))
        begin
            section = $signed(shifted[HIST_WIDTH-1:0]);
        end
        else if (shifted[SHIFTED_W-1])
        begin
            section = {1'b1, {(HIST_WIDTH-1){1'b0}}};
        end
        else
        begin
            section = {1'b0, {(HIST_WIDTH-1){1'b1}}};
        end
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Both sections close their recursion within this stage.
    always_comb
    begin
        alpha_next = section(ff_alpha, alpha_hist1_reg, alpha_hist2_reg, pole_a1, pole_a2);
        beta_next  = section(ff_beta, beta_hist1_reg, beta_hist2_reg, pole_a1, pole_a2);
    end

    // Stage valid and the output history of both sections.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            alpha_hist1_reg <= '0;
            alpha_hist2_reg <= '0;
            beta_hist1_reg  <= '0;
            beta_hist2_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                alpha_hist1_reg <= alpha_next;
                alpha_hist2_reg <= alpha_hist1_reg;
                beta_hist1_reg  <= beta_next;
                beta_hist2_reg  <= beta_hist1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= in_sample;
        end
    end

    // The newest history entry is the result of the item held here.
    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign y_alpha    = alpha_hist1_reg;
    assign y_beta     = beta_hist1_reg;

    // Each section's history shifts by one entry per item.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> alpha_hist2_reg == $past(alpha_hist1_reg))
        else $error("band-pass history did not shift with the item");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> beta_hist2_reg == $past(beta_hist1_reg))
        else $error("low-pass history did not shift with the item");

    // History holds while no item enters.
    assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(alpha_hist1_reg) && $stable(beta_hist1_reg))
        else $error("filter history changed without an item");

endmodule

`default_nettype wire

### hw/rtl/sqf_output.sv
`default_nettype none

module sqf_output
    import sqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample,
    input  wire logic signed [SAMPLE_WIDTH+HIST_FRAC-1:0] y_alpha,
    input  wire logic signed [SAMPLE_WIDTH+HIST_FRAC-1:0] y_beta,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]           in_phase,
    output logic signed [SAMPLE_WIDTH-1:0]           quadrature,
    output logic signed [SAMPLE_WIDTH-1:0]           error
);

    localparam int HIST_WIDTH = SAMPLE_WIDTH + HIST_FRAC;
    localparam logic [HIST_WIDTH:0] RND_HALF = (HIST_WIDTH + 1)'(1) << (HIST_FRAC - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_phase_reg;
    logic signed [SAMPLE_WIDTH-1:0] quadrature_reg;
    logic signed [SAMPLE_WIDTH-1:0] error_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_phase_next;
    logic signed [SAMPLE_WIDTH-1:0] quadrature_next;
    logic signed [SAMPLE_WIDTH-1:0] error_next;
    logic [SAMPLE_WIDTH:0]          diff;
    logic                           load;

    // Saturate a value with one extra integer bit to the sample width.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_one(
        input logic [SAMPLE_WIDTH:0] v
    );
        if (v[SAMPLE_WIDTH] == v[SAMPLE_WIDTH-1])
        begin
            sat_one = $signed(v[SAMPLE_WIDTH-1:0]);
        end
        else if (v[SAMPLE_WIDTH])
        begin
            sat_one = SAT_MIN;
        end
        else
        begin
            sat_one = SAT_MAX;
        end
    endfunction

    // Round a history value half-up to an integer sample and saturate.
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_out(
        input logic signed [HIST_WIDTH-1:0] y
    );
        logic [HIST_WIDTH:0] rnd;
        rnd       = (HIST_WIDTH + 1)'(y) + RND_HALF;
        round_out = sat_one(rnd[HIST_WIDTH:HIST_FRAC]);
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        in_phase_next   = round_out(y_alpha);
        quadrature_next = round_out(y_beta);
        diff            = (SAMPLE_WIDTH + 1)'(in_sample) - (SAMPLE_WIDTH + 1)'(in_phase_next);
        error_next      = sat_one(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Result register, held while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_phase_reg   <= in_phase_next;
            quadrature_reg <= quadrature_next;
            error_reg      <= error_next;
        end
    end

    assign out_valid  = valid_reg;
    assign in_phase   = in_phase_reg;
    assign quadrature = quadrature_reg;
    assign error      = error_reg;

endmodule

`default_nettype wire

### hw/rtl/sogi_quadrature_filter_unit.sv
// SOGI quadrature filter (Tustin-discretized second-order generalized integrator).
//
// Input items arrive on s_axis: one signed grid-voltage sample per item.
// Result items leave on m_axis: in-phase (band-pass), quadrature (low-pass)
// and error (sample minus in-phase), one result for every input item.
// Both sections share the pole coefficients; all eight Q2.30 coefficients
// are written over the APB port, which should only be done while no item
// is in flight.
//
// The datapath is four registered stages: input register, numerator
// products, the recursive pole update and the rounded result register.
// Throughput is one item per cycle while m_axis_tready stays high; the
// pole recursion closes within one stage, so the multiply-add path of
// that stage sets the clock rate.
//
// Reset clears the coefficients and the filter history to zero.
// When the receiver holds m_axis_tready low, the result register holds and
// the stages behind it fill up; s_axis_tready falls only once all are full.
`default_nettype none

module sogi_quadrature_filter_unit
    import sqf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32,
    localparam int IN_TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_WIDTH = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int PDATA_WIDTH     = (COEF_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_WIDTH     = ((COEF_WIDTH > 32) ? 3 : 2) + IDX_WIDTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input stream; tdata: sample
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    // Output stream; tdata: in_phase, quadrature, error
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0]      m_axis_tdata,
    // Coefficient register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_WIDTH-1:0]     paddr,
    input  wire logic [PDATA_WIDTH-1:0]     pwdata,
    output logic [PDATA_WIDTH-1:0]          prdata,
    output logic                            pready
);

    localparam int FF_WIDTH   = COEF_WIDTH + SAMPLE_WIDTH + FF_GUARD;
    localparam int HIST_WIDTH = SAMPLE_WIDTH + HIST_FRAC;

    logic signed [COEF_WIDTH-1:0]   bp_b0, bp_b1, bp_b2;
    logic signed [COEF_WIDTH-1:0]   lp_b0, lp_b1, lp_b2;
    logic signed [COEF_WIDTH-1:0]   pole_a1, pole_a2;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;

    logic                           ff_in_ready;
    logic                           ff_valid;
    logic signed [SAMPLE_WIDTH-1:0] ff_sample;
    logic signed [FF_WIDTH-1:0]     ff_alpha;
    logic signed [FF_WIDTH-1:0]     ff_beta;

    logic                           fb_in_ready;
    logic                           fb_valid;
    logic signed [SAMPLE_WIDTH-1:0] fb_sample;
    logic signed [HIST_WIDTH-1:0]   y_alpha;
    logic signed [HIST_WIDTH-1:0]   y_beta;

    logic                           out_in_ready;
    logic signed [SAMPLE_WIDTH-1:0] in_phase;
    logic signed [SAMPLE_WIDTH-1:0] quadrature;
    logic signed [SAMPLE_WIDTH-1:0] error;

    sqf_regs #(
        .COEF_WIDTH (COEF_WIDTH),
        .DATA_WIDTH (PDATA_WIDTH),
        .ADDR_WIDTH (PADDR_WIDTH)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bp_b0   (bp_b0),
        .bp_b1   (bp_b1),
        .bp_b2   (bp_b2),
        .lp_b0   (lp_b0),
        .lp_b1   (lp_b1),
        .lp_b2   (lp_b2),
        .pole_a1 (pole_a1),
        .pole_a2 (pole_a2)
    );

    // Input register.
    assign s_axis_tready = !in_valid_reg || ff_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_sample_reg <= $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
        end
    end

    sqf_feedforward #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_feedforward (
        .clk        (clk),
        .rst_n      (rst_n),
        .bp_b0      (bp_b0),
        .bp_b1      (bp_b1),
        .bp_b2      (bp_b2),
        .lp_b0      (lp_b0),
        .lp_b1      (lp_b1),
        .lp_b2      (lp_b2),
        .in_valid   (in_valid_reg),
        .in_ready   (ff_in_ready),
        .in_sample  (in_sample_reg),
        .out_valid  (ff_valid),
        .out_ready  (fb_in_ready),
        .out_sample (ff_sample),
        .ff_alpha   (ff_alpha),
        .ff_beta    (ff_beta)
    );

    sqf_feedback #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_feedback (
        .clk        (clk),
        .rst_n      (rst_n),
        .pole_a1    (pole_a1),
        .pole_a2    (pole_a2),
        .in_valid   (ff_valid),
        .in_ready   (fb_in_ready),
        .in_sample  (ff_sample),
        .ff_alpha   (ff_alpha),
        .ff_beta    (ff_beta),
        .out_valid  (fb_valid),
        .out_ready  (out_in_ready),
        .out_sample (fb_sample),
        .y_alpha    (y_alpha),
        .y_beta     (y_beta)
    );

    sqf_output #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_output (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fb_valid),
        .in_ready   (out_in_ready),
        .in_sample  (fb_sample),
        .y_alpha    (y_alpha),
        .y_beta     (y_beta),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .in_phase   (in_phase),
        .quadrature (quadrature),
        .error      (error)
    );

    // Pack the result fields, in_phase in the lowest bits.
    assign m_axis_tdata = OUT_TDATA_WIDTH'({error, quadrature, in_phase});

    // Input is refused only when every stage is full and the result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the result stage could move");

endmodule

`default_nettype wire

### tb/sv/sogi_quadrature_filter_unit_tb.sv
`timescale 1ns / 1ps

module sogi_quadrature_filter_unit_tb;
    import sqf_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PADDR_W     = 2 + IDX_WIDTH;
    localparam int COEF_FRAC   = 30;
    localparam int DRAIN_WAIT  = 8;
    localparam real PI         = 3.141592653589793;

    localparam logic signed [31:0] COEF_ONE = 32'sh4000_0000;
    localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;

    // One result item; the first member sits in the top bits of tdata.
    typedef struct packed {
        logic signed [15:0] error;
        logic signed [15:0] quadrature;
        logic signed [15:0] in_phase;
    } sogi_result_t;

    typedef enum {COEF_FULL, COEF_SMALL, COEF_CORNER} coef_mix_t;
    typedef enum {BURST_NOISE, BURST_STEP, BURST_SINE} burst_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Coefficients and filter history as the block should hold them.
    logic signed [31:0] coef_q [NUM_REGS];
    logic signed [15:0] x_prev1 = '0;
    logic signed [15:0] x_prev2 = '0;
    logic signed [31:0] bp_hist1 = '0;
    logic signed [31:0] bp_hist2 = '0;
    logic signed [31:0] lp_hist1 = '0;
    logic signed [31:0] lp_hist2 = '0;

    sogi_result_t expected_results[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_stalls_on = 1'b1;

    sogi_quadrature_filter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Sign-extend a 32-bit value to the width of the exact accumulator.
    function automatic logic signed [79:0] ext80(input logic signed [31:0] v);
        return 80'(v);
    endfunction

    // Clamp an exact value to a signed range of w bits.
    function automatic logic signed [31:0] saturate(input logic signed [79:0] v,
                                                    input int w);
        logic signed [79:0] top;
        logic signed [79:0] bot;
        top = (80'sd1 <<< (w - 1)) - 80'sd1;
        bot = -top - 80'sd1;
        if (v > top)
            return top[31:0];
        if (v < bot)
            return bot[31:0];
        return v[31:0];
    endfunction

    // One second-order section: exact sum of products, rounded half-up to the
    // history format and saturated there.
    function automatic logic signed [31:0] section_out(
        input logic signed [31:0] b0,
        input logic signed [31:0] b1,
        input logic signed [31:0] b2,
        input logic signed [15:0] x0,
        input logic signed [31:0] h1,
        input logic signed [31:0] h2
    );
        logic signed [79:0] acc;
        acc = ext80(b0) * (ext80(x0) <<< HIST_FRAC)
            + ext80(b1) * (ext80(x_prev1) <<< HIST_FRAC)
            + ext80(b2) * (ext80(x_prev2) <<< HIST_FRAC)
            - ext80(coef_q[REG_POLE_A1]) * ext80(h1)
            - ext80(coef_q[REG_POLE_A2]) * ext80(h2);
        acc = (acc + (80'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        return saturate(acc, 32);
    endfunction

    // History value rounded half-up to a whole sample and saturated.
    function automatic logic signed [15:0] round_to_sample(input logic signed [31:0] y);
        logic signed [79:0] r;
        r = (ext80(y) + (80'sd1 <<< (HIST_FRAC - 1))) >>> HIST_FRAC;
        return 16'(saturate(r, 16));
    endfunction

    // Expected in-phase, quadrature and error for one sample; advances history.
    function automatic sogi_result_t predict_result(input logic signed [15:0] s);
        logic signed [31:0] ya;
        logic signed [31:0] yb;
        logic signed [15:0] ip;
        sogi_result_t r;
        ya = section_out(coef_q[REG_BP_B0], coef_q[REG_BP_B1], coef_q[REG_BP_B2],
                         s, bp_hist1, bp_hist2);
        yb = section_out(coef_q[REG_LP_B0], coef_q[REG_LP_B1], coef_q[REG_LP_B2],
                         s, lp_hist1, lp_hist2);
        ip = round_to_sample(ya);
        r.in_phase   = ip;
        r.quadrature = round_to_sample(yb);
        r.error      = 16'(saturate(ext80(s) - ext80(ip), 16));
        x_prev2  = x_prev1;
        x_prev1  = s;
        bp_hist2 = bp_hist1;
        bp_hist1 = ya;
        lp_hist2 = lp_hist1;
        lp_hist1 = yb;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Sender gaps: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Send one sample item and record its expected result once accepted.
    task automatic send_sample(input logic signed [15:0] s);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = s;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_results.push_back(predict_result(s));
        @(negedge clk);
    endtask

    // Stop sending and let every outstanding result come out.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_coef(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== value)
            note_mismatch($sformatf("readback of %s", idx.name()), 48'(value), 48'(rdata));
    endtask

    task automatic write_coef(input reg_idx_t idx, input logic signed [31:0] value);
        logic [31:0] unused;
        wait_idle();
        apb_access(1'b1, idx, value, unused);
        coef_q[idx] = value;
        check_coef(idx, value);
    endtask

    task automatic write_all_coefs(input logic signed [31:0] value);
        for (int i = 0; i < NUM_REGS; i++)
            write_coef(reg_idx_t'(i), value);
    endtask

    function automatic logic signed [31:0] to_q30(input real v);
        return $rtoi(v * 1073741824.0);
    endfunction

    // Tustin-discretized SOGI coefficients for gain k, frequency f and step ts.
    task automatic set_sogi_coefs(input real k, input real f, input real ts);
        real wts;
        real x;
        real y;
        real d;
        wts = 2.0 * PI * f * ts;
        x = 2.0 * k * wts;
        y = wts * wts;
        d = x + y + 4.0;
        write_coef(REG_BP_B0, to_q30(x / d));
        write_coef(REG_BP_B1, '0);
        write_coef(REG_BP_B2, to_q30(-x / d));
        write_coef(REG_LP_B0, to_q30(k * y / d));
        write_coef(REG_LP_B1, to_q30(2.0 * k * y / d));
        write_coef(REG_LP_B2, to_q30(k * y / d));
        write_coef(REG_POLE_A1, to_q30(-2.0 * (4.0 - y) / d));
        write_coef(REG_POLE_A2, to_q30((4.0 + y - x) / d));
    endtask

    // After reset every coefficient reads zero, so both sections output zero.
    task automatic test_reset_defaults();
        for (int i = 0; i < NUM_REGS; i++)
            check_coef(reg_idx_t'(i), '0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
    endtask

    // Unity and negative-unity direct paths, including output and error overflow.
    task automatic test_unity_gain();
        write_coef(REG_BP_B0, COEF_ONE);
        write_coef(REG_LP_B0, -COEF_ONE);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sh0001);
        write_coef(REG_BP_B0, -COEF_ONE);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'shFFFF);
    endtask

    // Full-scale coefficients drive the history into saturation both ways.
    task automatic test_coef_extremes();
        write_all_coefs(COEF_MAX);
        repeat (3) send_sample(16'sh7FFF);
        repeat (3) send_sample(16'sh8000);
        write_all_coefs(COEF_MIN);
        repeat (3) send_sample(16'sh8000);
        repeat (3) send_sample(16'sh7FFF);
    endtask

    // Realistic SOGI settings fed with grid-like sine bursts, some noise and steps.
    task automatic test_sogi_tracking();
        real gain_set [4] = '{1.414, 0.5, 2.0, 1.0};
        real freq_set [4] = '{50.0, 60.0, 400.0, 50.0};
        real step_set [4] = '{1.0e-4, 5.0e-5, 1.0e-4, 5.0e-4};
        real amp;
        real omega;
        real theta;
        real v;
        int sent;
        int burst;
        burst_kind_t kind;
        for (int p = 0; p < 4; p++)
        begin
            set_sogi_coefs(gain_set[p], freq_set[p], step_set[p]);
            // The last setting runs with no idling on either side.
            tx_gaps_on   = (p != 3);
            rx_stalls_on = (p != 3);
            sent = 0;
            while (sent < 220)
            begin
                burst = $urandom_range(20, 80);
                case ($urandom_range(0, 9))
                    0:       kind = BURST_NOISE;
                    1:       kind = BURST_STEP;
                    default: kind = BURST_SINE;
                endcase
                amp   = real'($urandom_range(0, 40000));
                omega = 2.0 * PI * freq_set[p] * step_set[p]
                      * (0.8 + 0.4 * real'($urandom_range(0, 1000)) / 1000.0);
                theta = 2.0 * PI * real'($urandom_range(0, 1000)) / 1000.0;
                for (int n = 0; n < burst; n++)
                begin
                    case (kind)
                        BURST_NOISE: v = real'($signed(16'($urandom)));
                        BURST_STEP:  v = (n < burst / 2) ? 32767.0 : -32768.0;
                        default:     v = amp * $sin(theta + omega * n)
                                       + real'($urandom_range(0, 400)) - 200.0;
                    endcase
                    if (v > 32767.0)
                        v = 32767.0;
                    if (v < -32768.0)
                        v = -32768.0;
                    send_sample(16'($rtoi(v)));
                    sent++;
                end
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Arbitrary coefficient sets, stable or not, with mixed sample magnitudes.
    task automatic test_random_coefs();
        logic signed [31:0] c;
        logic signed [15:0] s;
        coef_mix_t mix;
        int r;
        for (int p = 0; p < 6; p++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mix = (p < 3) ? coef_mix_t'(p) : coef_mix_t'($urandom_range(0, 2));
                case (mix)
                    COEF_FULL:  c = $urandom;
                    COEF_SMALL: c = $signed($urandom_range(0, 32'h01FF_FFFF))
                                  - 32'sh0100_0000;
                    default:
                        case ($urandom_range(0, 4))
                            0:       c = COEF_MAX;
                            1:       c = COEF_MIN;
                            2:       c = COEF_ONE;
                            3:       c = -COEF_ONE;
                            default: c = '0;
                        endcase
                endcase
                write_coef(reg_idx_t'(i), c);
            end
            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    case ($urandom_range(0, 3))
                        0:       s = 16'sh7FFF;
                        1:       s = 16'sh8000;
                        2:       s = 16'sh0000;
                        default: s = 16'shFFFF;
                    endcase
                end
                else if (r < 65)
                    s = 16'($urandom);
                else
                    s = 16'($signed($urandom_range(0, 128)) - 64);
                send_sample(s);
            end
        end
    endtask

    // Receiver: random stalls, mostly short and a few long.
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && rx_stalls_on)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    stall_left = $urandom_range(1, 3);
                else if (r < 18)
                    stall_left = $urandom_range(10, 40);
            end
            m_axis_tready = (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        sogi_result_t got;
        sogi_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_results.size() == 0)
                note_mismatch("result with nothing expected", '0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got.in_phase !== want.in_phase)
                    note_mismatch("in_phase", 48'(want.in_phase), 48'(got.in_phase));
                if (got.quadrature !== want.quadrature)
                    note_mismatch("quadrature", 48'(want.quadrature),
                                  48'(got.quadrature));
                if (got.error !== want.error)
                    note_mismatch("error", 48'(want.error), 48'(got.error));
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Reset, then the tests in turn, then the verdict.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        foreach (coef_q[i])
            coef_q[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_unity_gain();
        test_coef_extremes();
        test_sogi_tracking();
        test_random_coefs();

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
